[src/serial_frame_receiver_checksum_defines.svh]
// assertion macros for the serial frame receiver checker
// needs clk and arst_n in the scope where the macros are used
`ifndef SERIAL_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH

// clocked assertion, disabled while reset is applied
`define SFRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sfrc checker: property failed");

// implication from a condition to a property on the next edge
`define SFRC_ASSERT_NEXT(lbl, cond, prop) \
	`SFRC_ASSERT(lbl, (cond) |=> (prop))

`endif

[src/sfrc_pkg.sv]
// types and constants of the serial frame receiver
// no dependencies
package sfrc_pkg;

	localparam int WIN_LEN = 41;
	localparam int NUM_CH  = 9;
	localparam int CH_W    = 4;
	localparam int CNT_W   = 7;

	localparam logic [7:0] HDR_B0    = 8'hFF;
	localparam logic [7:0] HDR_B1    = 8'h55;
	localparam logic [7:0] HDR_B2    = 8'hAA;
	localparam logic [7:0] KIND_DATA = 8'h10;
	localparam logic [7:0] KIND_CMD  = 8'h77;

	localparam logic [31:0]     POS_MAX = 32'h7FFF_FFFF;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

	typedef struct packed {
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic signed [31:0] value;
		logic               last;
	} out_item_t;

	// control handed to the word cells of the output chain
	typedef struct packed {
		logic load;
		logic shift;
	} word_ctl_t;

endpackage

[src/sfrc_stream_if.sv]
// valid/ready channel carrying one request payload
// payload type given at instantiation, normally from sfrc_pkg
interface sfrc_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/sfrc_byte_cell.sv]
// one byte cell of the receive window shift chain
// no dependencies
module sfrc_byte_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] d,
	output logic [7:0] q
);
	logic [7:0] byte_q;

	// take the byte at d whenever en is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;
endmodule

[src/sfrc_word_cell.sv]
// one channel word cell of the output shift chain
// depends on sfrc_pkg
module sfrc_word_cell
	import sfrc_pkg::*;
(
	input  logic               clk,
	input  word_ctl_t          ctl,
	input  logic [31:0]        raw_word,
	input  logic signed [31:0] next_value,
	output logic signed [31:0] value
);
	logic signed [31:0] value_q;
	logic [31:0]        conv;

	// sign quirk: words above the positive max fold as max minus word
	always_comb begin
		if (raw_word > POS_MAX) begin
			conv = POS_MAX - raw_word;
		end else begin
			conv = raw_word;
		end
	end

	// load a whole frame or move one place toward the output
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= signed'(conv);
		end else if (ctl.shift) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;
endmodule

[src/serial_frame_receiver_checksum.sv]
// channel  dir  payload                       handshake
// rx       in   rx_byte[7:0]                  valid/ready
// result   out  channel[3:0] value[31:0] last valid/ready
//
// one byte is taken per cycle while rx.ready is high; the fill count updates then,
// and the window and running checksum too unless the fill count is at BUFFER_LEN.
// a data frame with a good checksum loads nine word cells and rx is held off
// while they drain, one result per output request. reset clears the window, fill
// count, checksum and output state. results wait in the word cells while result.ready is low.
//
// top level of the serial frame receiver; depends on sfrc_pkg, sfrc_stream_if,
// sfrc_byte_cell and sfrc_word_cell
module serial_frame_receiver_checksum
	import sfrc_pkg::*;
#(
	parameter int BUFFER_LEN    = 64,
	parameter int CMD_FRAME_LEN = 7
) (
	input logic           clk,
	input logic           arst_n,
	sfrc_stream_if.sink   rx,
	sfrc_stream_if.source result
);
	localparam bit CMD_OK   = (CMD_FRAME_LEN >= 5) && (CMD_FRAME_LEN <= WIN_LEN);
	// start of a command header in the window before the shift
	localparam int CMD_BASE = CMD_OK ? (WIN_LEN + 1 - CMD_FRAME_LEN) : 1;

	logic [7:0]            win [WIN_LEN];
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      fill_next;
	logic [7:0]            sum_q;
	logic                  busy_q;
	logic [CH_W-1:0]       ch_q;
	logic                  take;
	logic                  full;
	logic                  shift_en;
	logic                  data_hit;
	logic                  cmd_hit;
	logic                  good;
	logic                  out_done;
	logic [7:0]            rx_b;
	word_ctl_t             wctl;
	logic signed [31:0]    wval [NUM_CH];

	assign rx_b     = rx.payload.rx_byte;
	assign take     = rx.valid && rx.ready;
	assign full     = fill_q >= CNT_W'(BUFFER_LEN);
	assign shift_en = take && !full;
	assign fill_next = fill_q + CNT_W'(1);

	// frame detection on the window as it will stand after the shift
	assign data_hit = (fill_next >= CNT_W'(WIN_LEN)) &&
		(win[1] == HDR_B0) && (win[2] == HDR_B1) &&
		(win[3] == HDR_B2) && (win[4] == KIND_DATA);
	assign cmd_hit = CMD_OK && (fill_next >= CNT_W'(CMD_FRAME_LEN)) &&
		(win[CMD_BASE] == HDR_B0) && (win[CMD_BASE + 1] == HDR_B1) &&
		(win[CMD_BASE + 2] == HDR_B2) && (win[CMD_BASE + 3] == KIND_CMD);
	// running sum holds the 40 bytes that precede the new checksum byte
	assign good = data_hit && (sum_q == rx_b);

	// receive window: a row of byte cells, newest at the top
	genvar k;
	generate
		for (k = 0; k < WIN_LEN; k++) begin : g_win
			if (k == WIN_LEN - 1) begin : g_top
				sfrc_byte_cell u_cell (
					.clk(clk), .arst_n(arst_n), .en(shift_en), .d(rx_b), .q(win[k])
				);
			end else begin : g_mid
				sfrc_byte_cell u_cell (
					.clk(clk), .arst_n(arst_n), .en(shift_en), .d(win[k + 1]), .q(win[k])
				);
			end
		end
	endgenerate

	// fill count and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (take) begin
			if (full || data_hit || cmd_hit) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_next;
			end
			if (!full) begin
				sum_q <= sum_q - win[1] + rx_b;
			end
		end
	end

	// output sequencing over the word cells
	assign out_done = result.valid && result.ready;
	assign wctl.load  = shift_en && good;
	assign wctl.shift = out_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else if (wctl.load) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
		end else if (out_done) begin
			if (ch_q == LAST_CH) begin
				busy_q <= 1'b0;
			end
			ch_q <= ch_q + CH_W'(1);
		end
	end

	// output chain: word cell 0 faces the result channel
	genvar c;
	generate
		for (c = 0; c < NUM_CH; c++) begin : g_word
			logic [31:0]        raw;
			logic signed [31:0] nxt;
			assign raw = {win[5 + 4*c], win[6 + 4*c], win[7 + 4*c], win[8 + 4*c]};
			if (c == NUM_CH - 1) begin : g_end
				assign nxt = '0;
			end else begin : g_link
				assign nxt = wval[c + 1];
			end
			sfrc_word_cell u_cell (
				.clk(clk), .ctl(wctl), .raw_word(raw), .next_value(nxt), .value(wval[c])
			);
		end
	endgenerate

	// channel ports
	assign rx.ready               = !busy_q;
	assign result.valid           = busy_q;
	assign result.payload.channel = ch_q;
	assign result.payload.value   = wval[0];
	assign result.payload.last    = (ch_q == LAST_CH);
endmodule

[src/sfrc_checker.sv]
// port-level checker for the serial frame receiver, bound to the top level
// depends on sfrc_pkg and serial_frame_receiver_checksum_defines.svh
`include "serial_frame_receiver_checksum_defines.svh"

module sfrc_checker
	import sfrc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [CH_W-1:0]    channel,
	input logic signed [31:0] value,
	input logic               last
);
	// last flags exactly the final channel
	`SFRC_ASSERT(a_last_ch, out_valid |-> (last == (channel == LAST_CH)))
	// a stalled result holds
	`SFRC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(channel) && $stable(value))
	// channels of one frame come in order without gaps
	`SFRC_ASSERT_NEXT(a_seq, out_valid && out_ready && !last, out_valid && (channel == $past(channel) + CH_W'(1)))
	// a frame ends cleanly and input is held off while results drain
	`SFRC_ASSERT_NEXT(a_end, out_valid && out_ready && last, !out_valid)
	`SFRC_ASSERT(a_excl, !(in_ready && out_valid))
endmodule

bind serial_frame_receiver_checksum sfrc_checker u_sfrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (rx.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.channel  (result.payload.channel),
	.value    (result.payload.value),
	.last     (result.payload.last)
);
